/* rtl/core/ste_pkg.sv */
package ste_pkg;

  localparam int unsigned POS_W      = 24;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_IDX_W  = 3;

  localparam int unsigned FRAC_BITS   = 24;
  localparam int unsigned SHIFT_FRAC  = 16;
  localparam int unsigned BLOCK_LOG2  = 4;
  localparam int unsigned BLOCK_TEXELS = 16;
  localparam int unsigned EXTENT_LIMIT = 256;

  localparam int unsigned PROD_W   = POS_W + CFG_W;
  localparam int unsigned SHTERM_W = CFG_W + SHIFT_FRAC;
  localparam int unsigned PAIR_W   = PROD_W + 1;
  localparam int unsigned PROJ_W   = PROD_W + 2;
  localparam int unsigned BLK_SHIFT = FRAC_BITS + BLOCK_LOG2;
  localparam int unsigned BMIN_W   = PROJ_W - BLK_SHIFT;
  localparam int unsigned BMAX_W   = BMIN_W + 1;
  localparam int unsigned MIN_OUT_W = 32;
  localparam int unsigned EXT_OUT_W = 31;

  localparam logic signed [PROJ_W-1:0] LOW_INIT  = PROJ_W'(64'sd999999 * 64'sd16777216);
  localparam logic signed [PROJ_W-1:0] HIGH_INIT = PROJ_W'(-64'sd99999 * 64'sd16777216);
  localparam logic [PROJ_W:0] BLK_ROUND = (PROJ_W+1)'((64'd1 << BLK_SHIFT) - 64'd1);

  localparam logic [REG_IDX_W-1:0] REG_S_AXIS_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_S_AXIS_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_S_AXIS_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_S_SHIFT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_T_AXIS_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_T_AXIS_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_T_AXIS_Z = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_T_SHIFT  = 3'd7;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    last_vertex;
    logic                    unlimited_surface;
  } in_item_t;

  typedef struct packed {
    logic signed [MIN_OUT_W-1:0] tex_min_s;
    logic signed [MIN_OUT_W-1:0] tex_min_t;
    logic [EXT_OUT_W-1:0]        extent_s;
    logic [EXT_OUT_W-1:0]        extent_t;
    logic                        extent_error;
  } out_item_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] x;
    logic signed [CFG_W-1:0] y;
    logic signed [CFG_W-1:0] z;
    logic signed [CFG_W-1:0] shift;
  } axis_t;

  typedef struct packed {
    logic signed [PROJ_W-1:0] vs;
    logic signed [PROJ_W-1:0] vt;
    logic                     last;
    logic                     unlimited;
  } q_entry_t;

endpackage

/* rtl/core/ste_front.sv */
module ste_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ste_pkg::in_item_t in_data_i,
  input  ste_pkg::axis_t    s_axis_i,
  input  ste_pkg::axis_t    t_axis_i,
  output logic              ent_valid_o,
  input  logic              ent_ready_i,
  output ste_pkg::q_entry_t ent_o
);
  import ste_pkg::*;

  logic adv;
  logic v1_q, v2_q, v3_q;

  logic signed [PROD_W-1:0]   prod_s_q [3];
  logic signed [PROD_W-1:0]   prod_t_q [3];
  logic signed [SHTERM_W-1:0] sh_s_q, sh_t_q;
  logic                       last1_q, unl1_q;

  logic signed [PAIR_W-1:0]   pa_s_q, pb_s_q, pa_t_q, pb_t_q;
  logic                       last2_q, unl2_q;

  q_entry_t ent_q;

  assign adv        = !v3_q || ent_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_s_q[0] <= in_data_i.pos_x * s_axis_i.x;
      prod_s_q[1] <= in_data_i.pos_y * s_axis_i.y;
      prod_s_q[2] <= in_data_i.pos_z * s_axis_i.z;
      prod_t_q[0] <= in_data_i.pos_x * t_axis_i.x;
      prod_t_q[1] <= in_data_i.pos_y * t_axis_i.y;
      prod_t_q[2] <= in_data_i.pos_z * t_axis_i.z;
      sh_s_q      <= {s_axis_i.shift, {SHIFT_FRAC{1'b0}}};
      sh_t_q      <= {t_axis_i.shift, {SHIFT_FRAC{1'b0}}};
      last1_q     <= in_data_i.last_vertex;
      unl1_q      <= in_data_i.unlimited_surface;

      pa_s_q  <= PAIR_W'(prod_s_q[0]) + PAIR_W'(prod_s_q[1]);
      pb_s_q  <= PAIR_W'(prod_s_q[2]) + PAIR_W'(sh_s_q);
      pa_t_q  <= PAIR_W'(prod_t_q[0]) + PAIR_W'(prod_t_q[1]);
      pb_t_q  <= PAIR_W'(prod_t_q[2]) + PAIR_W'(sh_t_q);
      last2_q <= last1_q;
      unl2_q  <= unl1_q;

      ent_q.vs        <= PROJ_W'(pa_s_q) + PROJ_W'(pb_s_q);
      ent_q.vt        <= PROJ_W'(pa_t_q) + PROJ_W'(pb_t_q);
      ent_q.last      <= last2_q;
      ent_q.unlimited <= unl2_q;
    end
  end

  assign ent_valid_o = v3_q;
  assign ent_o       = ent_q;

endmodule

/* rtl/core/ste_queue.sv */
module ste_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  ste_pkg::q_entry_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output ste_pkg::q_entry_t pop_data_o
);
  import ste_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/ste_back.sv */
module ste_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ent_valid_i,
  output logic               ent_ready_o,
  input  ste_pkg::q_entry_t  ent_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ste_pkg::out_item_t out_data_o
);
  import ste_pkg::*;

  localparam int unsigned DIFF_W = BMAX_W + 1;
  localparam int unsigned MIN_W  = BMIN_W + BLOCK_LOG2;
  localparam int unsigned EXT_W  = DIFF_W + BLOCK_LOG2;

  function automatic logic signed [MIN_OUT_W-1:0] sat_min(input logic signed [MIN_W-1:0] m);
    if (!m[MIN_W-1] && |m[MIN_W-2:MIN_OUT_W-1]) begin
      return {1'b0, {(MIN_OUT_W-1){1'b1}}};
    end else if (m[MIN_W-1] && !(&m[MIN_W-2:MIN_OUT_W-1])) begin
      return {1'b1, {(MIN_OUT_W-1){1'b0}}};
    end
    return m[MIN_OUT_W-1:0];
  endfunction

  function automatic logic [EXT_OUT_W-1:0] sat_ext(input logic signed [EXT_W-1:0] e);
    if (e[EXT_W-1]) begin
      return EXT_OUT_W'(BLOCK_TEXELS);
    end else if (|e[EXT_W-2:EXT_OUT_W]) begin
      return '1;
    end else if (e[EXT_OUT_W-1:0] < EXT_OUT_W'(BLOCK_TEXELS)) begin
      return EXT_OUT_W'(BLOCK_TEXELS);
    end
    return e[EXT_OUT_W-1:0];
  endfunction

  function automatic logic is_big(input logic signed [EXT_W-1:0] e);
    return !e[EXT_W-1] && (e[EXT_W-2:0] > (EXT_W-1)'(EXTENT_LIMIT));
  endfunction

  logic signed [PROJ_W-1:0] lo_s_q, hi_s_q, lo_t_q, hi_t_q;
  logic signed [PROJ_W-1:0] lo_s_d, hi_s_d, lo_t_d, hi_t_d;

  logic                     f1_v_q, f2_v_q, out_v_q;
  logic signed [PROJ_W-1:0] f1_lo_s_q, f1_hi_s_q, f1_lo_t_q, f1_hi_t_q;
  logic                     f1_unl_q;
  logic signed [BMIN_W-1:0] bmin_s_q, bmin_t_q;
  logic signed [BMAX_W-1:0] bmax_s_q, bmax_t_q;
  logic                     f2_unl_q;
  out_item_t                out_q, res;

  logic             out_free, f2_acc, f1_acc, pop;
  logic [PROJ_W:0]  hc_s, hc_t;
  logic signed [DIFF_W-1:0] diff_s, diff_t;
  logic signed [EXT_W-1:0]  ext_s, ext_t;
  logic signed [MIN_W-1:0]  min_s, min_t;

  assign out_free    = !out_v_q || out_ready_i;
  assign f2_acc      = !f2_v_q || out_free;
  assign f1_acc      = !f1_v_q || f2_acc;
  assign ent_ready_o = !ent_i.last || f1_acc;
  assign pop         = ent_valid_i && ent_ready_o;

  always_comb begin
    lo_s_d = (ent_i.vs < lo_s_q) ? ent_i.vs : lo_s_q;
    hi_s_d = (ent_i.vs > hi_s_q) ? ent_i.vs : hi_s_q;
    lo_t_d = (ent_i.vt < lo_t_q) ? ent_i.vt : lo_t_q;
    hi_t_d = (ent_i.vt > hi_t_q) ? ent_i.vt : hi_t_q;
  end

  assign hc_s = (PROJ_W+1)'(f1_hi_s_q) + BLK_ROUND;
  assign hc_t = (PROJ_W+1)'(f1_hi_t_q) + BLK_ROUND;

  always_comb begin
    diff_s = DIFF_W'(bmax_s_q) - DIFF_W'(bmin_s_q);
    diff_t = DIFF_W'(bmax_t_q) - DIFF_W'(bmin_t_q);
    ext_s  = {diff_s, {BLOCK_LOG2{1'b0}}};
    ext_t  = {diff_t, {BLOCK_LOG2{1'b0}}};
    min_s  = {bmin_s_q, {BLOCK_LOG2{1'b0}}};
    min_t  = {bmin_t_q, {BLOCK_LOG2{1'b0}}};
    res.tex_min_s    = sat_min(min_s);
    res.tex_min_t    = sat_min(min_t);
    res.extent_s     = sat_ext(ext_s);
    res.extent_t     = sat_ext(ext_t);
    res.extent_error = !f2_unl_q && (is_big(ext_s) || is_big(ext_t));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_s_q  <= LOW_INIT;
      lo_t_q  <= LOW_INIT;
      hi_s_q  <= HIGH_INIT;
      hi_t_q  <= HIGH_INIT;
      f1_v_q  <= 1'b0;
      f2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (pop) begin
        if (ent_i.last) begin
          lo_s_q <= LOW_INIT;
          lo_t_q <= LOW_INIT;
          hi_s_q <= HIGH_INIT;
          hi_t_q <= HIGH_INIT;
        end else begin
          lo_s_q <= lo_s_d;
          lo_t_q <= lo_t_d;
          hi_s_q <= hi_s_d;
          hi_t_q <= hi_t_d;
        end
      end
      if (f1_acc) begin
        f1_v_q <= pop && ent_i.last;
      end
      if (f2_acc) begin
        f2_v_q <= f1_v_q;
      end
      if (out_free) begin
        out_v_q <= f2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_acc && pop && ent_i.last) begin
      f1_lo_s_q <= lo_s_d;
      f1_hi_s_q <= hi_s_d;
      f1_lo_t_q <= lo_t_d;
      f1_hi_t_q <= hi_t_d;
      f1_unl_q  <= ent_i.unlimited;
    end
    if (f2_acc && f1_v_q) begin
      bmin_s_q <= f1_lo_s_q[PROJ_W-1:BLK_SHIFT];
      bmin_t_q <= f1_lo_t_q[PROJ_W-1:BLK_SHIFT];
      bmax_s_q <= hc_s[PROJ_W:BLK_SHIFT];
      bmax_t_q <= hc_t[PROJ_W:BLK_SHIFT];
      f2_unl_q <= f1_unl_q;
    end
    if (out_free && f2_v_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/surface_texture_extents.sv */
// One vertex per cycle while no back-pressure from the queue or the output stalls
// the front; the per-axis min/max tracker update is the only loop.
// Front pipeline: multiply, then two adds.
// Back: tracker, block floor/ceil, saturation and output register.
// Reset clears all valid state, the configuration registers to zero and the
// trackers to their start values; vertices are accepted from the first cycle.
module surface_texture_extents #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ste_pkg::in_item_t             in_data_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ste_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ste_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ste_pkg::out_item_t            out_data_o
);
  import ste_pkg::*;

  logic [NUM_REGS-1:0][CFG_W-1:0] cfg_q;
  axis_t    s_axis, t_axis;
  logic     fr_valid, fr_ready, bk_valid, bk_ready;
  q_entry_t fr_ent, bk_ent;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o && cfg_index_i < CFG_IDX_W'(NUM_REGS)) begin
      cfg_q[cfg_index_i[REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  assign s_axis = '{x: cfg_q[REG_S_AXIS_X], y: cfg_q[REG_S_AXIS_Y],
                    z: cfg_q[REG_S_AXIS_Z], shift: cfg_q[REG_S_SHIFT]};
  assign t_axis = '{x: cfg_q[REG_T_AXIS_X], y: cfg_q[REG_T_AXIS_Y],
                    z: cfg_q[REG_T_AXIS_Z], shift: cfg_q[REG_T_SHIFT]};

  ste_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .s_axis_i    (s_axis),
    .t_axis_i    (t_axis),
    .ent_valid_o (fr_valid),
    .ent_ready_i (fr_ready),
    .ent_o       (fr_ent)
  );

  ste_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_ent),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_ent)
  );

  ste_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (bk_valid),
    .ent_ready_o (bk_ready),
    .ent_i       (bk_ent),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/core/ste_checker.sv */
module ste_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input ste_pkg::out_item_t out_data_i
);
  import ste_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_ext_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.extent_s >= EXT_OUT_W'(BLOCK_TEXELS) &&
                    out_data_i.extent_t >= EXT_OUT_W'(BLOCK_TEXELS))
    else $error("extent below one block");

  a_min_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.tex_min_s[BLOCK_LOG2-1:0] == '0 ||
                     out_data_i.tex_min_s == 32'sh7fffffff) &&
                    (out_data_i.tex_min_t[BLOCK_LOG2-1:0] == '0 ||
                     out_data_i.tex_min_t == 32'sh7fffffff))
    else $error("texture minimum not block aligned");

  a_err_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.extent_error |->
      out_data_i.extent_s > EXT_OUT_W'(EXTENT_LIMIT) ||
      out_data_i.extent_t > EXT_OUT_W'(EXTENT_LIMIT))
    else $error("extent error without large extent");

endmodule

bind surface_texture_extents ste_checker u_ste_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
